// ----- rtl/core/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int Capacity  = 16;
  localparam int KeyBits   = 16;
  localparam int FieldKeyW = 16;
  localparam int HandleW   = 16;
  localparam int CountW    = 5;
  localparam int StatusW   = 2;

  localparam int StoreKeyW = (KeyBits < FieldKeyW) ? KeyBits : FieldKeyW;
  localparam int CntW      = $clog2(Capacity + 1);

  typedef enum logic {
    MODE_ENQ = 1'b0,
    MODE_DEQ = 1'b1
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic                 enq;
    logic                 deq;
    logic [StoreKeyW-1:0] key;
    logic [HandleW-1:0]   handle;
    logic [CntW-1:0]      count;
  } cell_ctrl_t;

endpackage

// ----- rtl/core/spq_req_if.sv -----
// ----------------------------------------------------------------------------
// spq_req_if
// Request channel: enqueue or dequeue transaction.
// ----------------------------------------------------------------------------
interface spq_req_if
  import spq_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic                 mode;
  logic [FieldKeyW-1:0] item_key;
  logic [HandleW-1:0]   item_handle;

  modport source (output valid, output mode, output item_key, output item_handle,
                  input ready);
  modport sink   (input valid, input mode, input item_key, input item_handle,
                  output ready);
endinterface

// ----- rtl/core/spq_rsp_if.sv -----
// ----------------------------------------------------------------------------
// spq_rsp_if
// Response channel: status, dequeued entry and occupancy.
// ----------------------------------------------------------------------------
interface spq_rsp_if
  import spq_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [StatusW-1:0]   status;
  logic [FieldKeyW-1:0] out_key;
  logic [HandleW-1:0]   out_handle;
  logic [CountW-1:0]    entry_count;

  modport source (output valid, output status, output out_key, output out_handle,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input out_key, input out_handle,
                  input entry_count, output ready);
endinterface

// ----- rtl/core/spq_cell.sv -----
// ----------------------------------------------------------------------------
// spq_cell
// One queue slot: compares the incoming key, then loads the new entry,
// takes the left neighbor (insert shift) or the right neighbor (pop shift).
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  logic                 clk_i,
  input  logic [CntW-1:0]      idx_i,
  input  cell_ctrl_t           ctrl_i,
  input  logic                 left_goes_i,
  input  logic [StoreKeyW-1:0] left_key_i,
  input  logic [HandleW-1:0]   left_handle_i,
  input  logic [StoreKeyW-1:0] right_key_i,
  input  logic [HandleW-1:0]   right_handle_i,
  output logic                 goes_o,
  output logic [StoreKeyW-1:0] key_o,
  output logic [HandleW-1:0]   handle_o
);

  logic [StoreKeyW-1:0] key_q, key_d;
  logic [HandleW-1:0]   handle_q, handle_d;
  logic                 occupied;

  // slot holds an entry; goes_o marks a slot at or past the insertion point
  assign occupied = idx_i < ctrl_i.count;
  assign goes_o   = !occupied || (ctrl_i.key <= key_q);

  always_comb begin
    key_d    = key_q;
    handle_d = handle_q;
    if (ctrl_i.enq) begin
      if (left_goes_i) begin
        key_d    = left_key_i;
        handle_d = left_handle_i;
      end else if (goes_o) begin
        key_d    = ctrl_i.key;
        handle_d = ctrl_i.handle;
      end
    end else if (ctrl_i.deq) begin
      key_d    = right_key_i;
      handle_d = right_handle_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    handle_q <= handle_d;
  end

  assign key_o    = key_q;
  assign handle_o = handle_q;

endmodule

// ----- rtl/core/sorted_priority_queue_core.sv -----
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// Bounded priority queue kept in ascending key order in a row of cells.
// ----------------------------------------------------------------------------
// Each request transaction (enqueue or dequeue) yields one response
// transaction via the response register. Every cell compares the new key
// against its own entry in parallel, so a sorted insert or a head pop moves
// all cells at once; a request is accepted every cycle while the response
// register is empty or being drained. Among equal keys the newest entry
// leaves first. Enqueue on a full queue and dequeue on an empty one leave the
// contents untouched and report it in status. No clearing pass after reset.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core
  import spq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_req_if.sink   req_i,
  spq_rsp_if.source rsp_o
);

  logic [CntW-1:0]      count_q, count_d;
  logic                 rsp_valid_q;
  logic [StatusW-1:0]   status_q, status_d;
  logic [FieldKeyW-1:0] out_key_q, out_key_d;
  logic [HandleW-1:0]   out_handle_q, out_handle_d;
  logic [CountW-1:0]    entry_count_q;
  logic                 fire, is_full, is_empty;
  cell_ctrl_t           ctrl;

  logic                 goes   [Capacity];
  logic [StoreKeyW-1:0] keys   [Capacity];
  logic [HandleW-1:0]   hdls   [Capacity];

  logic [StoreKeyW+FieldKeyW-1:0] head_key_ext;
  logic [CntW+CountW-1:0]         count_ext;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign fire        = req_i.valid && req_i.ready;
  assign is_full     = count_q == CntW'(Capacity);
  assign is_empty    = count_q == '0;

  assign ctrl.enq    = fire && (req_i.mode == MODE_ENQ) && !is_full;
  assign ctrl.deq    = fire && (req_i.mode == MODE_DEQ) && !is_empty;
  assign ctrl.key    = req_i.item_key[StoreKeyW-1:0];
  assign ctrl.handle = req_i.item_handle;
  assign ctrl.count  = count_q;

  assign head_key_ext = {{FieldKeyW{1'b0}}, keys[0]};
  assign count_ext    = {{CountW{1'b0}}, count_d};

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic                 l_goes;
    logic [StoreKeyW-1:0] l_key, r_key;
    logic [HandleW-1:0]   l_hdl, r_hdl;

    if (i == 0) begin : g_first
      assign l_goes = 1'b0;
      assign l_key  = '0;
      assign l_hdl  = '0;
    end else begin : g_mid
      assign l_goes = goes[i-1];
      assign l_key  = keys[i-1];
      assign l_hdl  = hdls[i-1];
    end

    if (i == Capacity - 1) begin : g_last
      assign r_key = '0;
      assign r_hdl = '0;
    end else begin : g_inner
      assign r_key = keys[i+1];
      assign r_hdl = hdls[i+1];
    end

    spq_cell u_cell (
      .clk_i          (clk_i),
      .idx_i          (CntW'(i)),
      .ctrl_i         (ctrl),
      .left_goes_i    (l_goes),
      .left_key_i     (l_key),
      .left_handle_i  (l_hdl),
      .right_key_i    (r_key),
      .right_handle_i (r_hdl),
      .goes_o         (goes[i]),
      .key_o          (keys[i]),
      .handle_o       (hdls[i])
    );
  end

  always_comb begin
    count_d      = count_q;
    status_d     = STATUS_OK;
    out_key_d    = '0;
    out_handle_d = '0;
    if (req_i.mode == MODE_ENQ) begin
      if (is_full) begin
        status_d = STATUS_FULL;
      end else begin
        count_d = count_q + CntW'(1);
      end
    end else begin
      if (is_empty) begin
        status_d = STATUS_EMPTY;
      end else begin
        count_d      = count_q - CntW'(1);
        out_key_d    = head_key_ext[FieldKeyW-1:0];
        out_handle_d = hdls[0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        count_q     <= count_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q      <= status_d;
      out_key_q     <= out_key_d;
      out_handle_q  <= out_handle_d;
      entry_count_q <= count_ext[CountW-1:0];
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.out_key     = out_key_q;
  assign rsp_o.out_handle  = out_handle_q;
  assign rsp_o.entry_count = entry_count_q;

endmodule

// ----- test/tb_sorted_priority_queue_core.sv -----
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue_core
// Self-checking testbench for the sorted priority queue core.
// ----------------------------------------------------------------------------
// A shadow copy of the queue contents is updated for every accepted request
// transaction. It predicts the status, the dequeued entry and the occupancy,
// and each response transaction is checked against the oldest prediction.
// A short directed run covers empty and full cases, the key and handle
// extremes, and equal keys. A biased random run follows, in which the
// queue is repeatedly filled and emptied. The sender runs in bursts with
// gaps, and the receiver stalls on a changing pattern.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue_core;
  import spq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    status_e              status;
    logic [FieldKeyW-1:0] key;
    logic [HandleW-1:0]   handle;
    logic [CountW-1:0]    count;
  } pq_rsp_t;

  class pq_shadow;
    logic [StoreKeyW-1:0] held_key[$];
    logic [HandleW-1:0]   held_handle[$];
    pq_rsp_t              due_rsp[$];
    int                   errors;

    function void note_request(logic m, logic [FieldKeyW-1:0] k, logic [HandleW-1:0] h);
      pq_rsp_t              r;
      int                   pos;
      logic [StoreKeyW-1:0] sk;
      sk       = k[StoreKeyW-1:0];
      r.status = STATUS_OK;
      r.key    = '0;
      r.handle = '0;
      if (m == MODE_ENQ) begin
        if (held_key.size() >= Capacity) begin
          r.status = STATUS_FULL;
        end else begin
          // new entry goes ahead of the first equal or larger key
          pos = held_key.size();
          for (int i = 0; i < held_key.size(); i++) begin
            if (sk <= held_key[i]) begin
              pos = i;
              break;
            end
          end
          held_key.insert(pos, sk);
          held_handle.insert(pos, h);
        end
      end else begin
        if (held_key.size() == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          r.key    = FieldKeyW'(held_key.pop_front());
          r.handle = held_handle.pop_front();
        end
      end
      r.count = CountW'(held_key.size());
      due_rsp.push_back(r);
    endfunction

    function void check_response(logic [StatusW-1:0] st, logic [FieldKeyW-1:0] k,
                                 logic [HandleW-1:0] h, logic [CountW-1:0] c);
      pq_rsp_t e;
      if (due_rsp.size() == 0) begin
        $error("response with no request outstanding");
        errors++;
        return;
      end
      e = due_rsp.pop_front();
      if (st !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, st);
        errors++;
      end
      if (k !== e.key) begin
        $error("out_key: expected %h, got %h", e.key, k);
        errors++;
      end
      if (h !== e.handle) begin
        $error("out_handle: expected %h, got %h", e.handle, h);
        errors++;
      end
      if (c !== e.count) begin
        $error("entry_count: expected %0d, got %0d", e.count, c);
        errors++;
      end
    endfunction

    function int outstanding();
      return due_rsp.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  spq_req_if req_if ();
  spq_rsp_if rsp_if ();

  sorted_priority_queue_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  pq_shadow shadow;
  int       burst_left;
  int       issued;
  logic [15:0] stall_pat;
  logic [5:0]  stall_pos;

  always #1 clk_i = ~clk_i;

  // transaction monitor on both channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        shadow.note_request(req_if.mode, req_if.item_key, req_if.item_handle);
      end
      if (rsp_if.valid && rsp_if.ready) begin
        shadow.check_response(rsp_if.status, rsp_if.out_key, rsp_if.out_handle,
                              rsp_if.entry_count);
      end
    end
  end

  // receiver stall pattern, reloaded each time the 6-bit position counter wraps
  always @(posedge clk_i) begin
    if (stall_pos == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pat = '1;
        1: stall_pat = 16'($urandom);
        2: stall_pat = 16'($urandom | $urandom);
        default: stall_pat = 16'h000f;
      endcase
    end
    rsp_if.ready <= stall_pat[stall_pos[3:0]];
    stall_pos = stall_pos + 1'b1;
  end

  task automatic send_req(input mode_e m, input logic [FieldKeyW-1:0] k,
                          input logic [HandleW-1:0] h);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    req_if.valid       <= 1'b1;
    req_if.mode        <= m;
    req_if.item_key    <= k;
    req_if.item_handle <= h;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    issued++;
  endtask

  task automatic drain_rsp();
    req_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (shadow.outstanding() != 0) @(posedge clk_i);
  endtask

  function automatic logic [FieldKeyW-1:0] pick_key();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return FieldKeyW'($urandom_range(0, 7));
      4: return FieldKeyW'($urandom_range(16'hfff8, 16'hffff));
      default: return FieldKeyW'($urandom);
    endcase
  endfunction

  function automatic logic [HandleW-1:0] pick_handle();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return HandleW'($urandom);
    endcase
  endfunction

  initial begin
    int enq_pct;
    int seg_len;
    shadow             = new();
    burst_left         = 0;
    issued             = 0;
    stall_pos          = '0;
    stall_pat          = '1;
    rst_ni             = 1'b0;
    req_if.valid       = 1'b0;
    req_if.mode        = MODE_ENQ;
    req_if.item_key    = '0;
    req_if.item_handle = '0;
    rsp_if.ready       = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty pop, extremes, equal keys, fill to full, refused push
    send_req(MODE_DEQ, '0, '0);
    send_req(MODE_ENQ, 16'h8000, 16'h0000);
    send_req(MODE_ENQ, 16'hffff, 16'hffff);
    send_req(MODE_ENQ, 16'h0000, 16'h0001);
    send_req(MODE_ENQ, 16'h8000, 16'h0002);
    send_req(MODE_ENQ, 16'h8000, 16'h0003);
    send_req(MODE_ENQ, 16'h0000, 16'hffff);
    send_req(MODE_ENQ, 16'hffff, 16'h0000);
    for (int i = 1; i <= Capacity - 7; i++) begin
      send_req(MODE_ENQ, FieldKeyW'(i * 7013), HandleW'(16'h5a5a ^ i));
    end
    send_req(MODE_ENQ, 16'h1234, 16'habcd);
    repeat (4) send_req(MODE_DEQ, '0, '0);
    drain_rsp();

    // random: segments biased toward filling, emptying or holding level
    while (issued < 720) begin
      case ($urandom_range(0, 2))
        0: enq_pct = 80;
        1: enq_pct = 20;
        default: enq_pct = 50;
      endcase
      seg_len = $urandom_range(10, 60);
      repeat (seg_len) begin
        if ($urandom_range(1, 100) <= enq_pct) begin
          send_req(MODE_ENQ, pick_key(), pick_handle());
        end else begin
          send_req(MODE_DEQ, FieldKeyW'($urandom), HandleW'($urandom));
        end
      end
      if ($urandom_range(0, 5) == 0) drain_rsp();
    end

    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (shadow.outstanding() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (shadow.errors == 0) begin
      $display("tb_sorted_priority_queue_core: clean");
    end else begin
      $display("tb_sorted_priority_queue_core: errors");
    end
    $finish;
  end

  initial begin
    #500000;
    $display("tb_sorted_priority_queue_core: errors");
    $finish;
  end

endmodule

// ----- sorted_priority_queue_core.f -----
rtl/core/spq_pkg.sv
rtl/core/spq_req_if.sv
rtl/core/spq_rsp_if.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue_core.sv
test/tb_sorted_priority_queue_core.sv
